// ===== rtl/core/bedf_pkg.sv =====
package bedf_pkg;

  localparam int STAMP_W    = 48;
  localparam int ADDR_W     = 32;
  localparam int THRESH_W   = 7;
  localparam int WINDOW_W   = 32;
  localparam int COUNT_OUT_W = 7;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_US       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BROADCAST_ADDR  = 2'd2;

  localparam logic [THRESH_W-1:0] RESET_THRESHOLD = 7'd50;
  localparam logic [WINDOW_W-1:0] RESET_WINDOW_US = 32'd60000000;
  localparam logic [ADDR_W-1:0]   RESET_BCAST     = 32'hFFFF_FFFF;

  localparam logic [7:0] PROTO_ICMP      = 8'd1;
  localparam logic [7:0] ICMP_ECHO_REQ   = 8'd8;
  localparam logic [7:0] ICMP_CODE_PLAIN = 8'd0;

  typedef struct packed {
    logic capture;
    logic pop;
    logic push;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic nonempty;
    logic aged;
  } status_t;

endpackage

// ===== rtl/core/bedf_ctrl.sv =====
module bedf_ctrl
  import bedf_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_EVAL  = 5'b00100,
    S_PUSH  = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = status.match ? S_EVAL : S_DONE;
      end
      S_EVAL: begin
        if (status.nonempty && status.aged) begin
          cmd.pop = 1'b1;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.push   = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef SYNTHESIS
  a_pop_only_in_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> state == S_EVAL)
    else $error("pop outside eviction state");
  a_no_load_over_held: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");
  a_push_after_check: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> state == S_DONE)
    else $error("push not followed by result");
`endif

endmodule

// ===== rtl/core/bedf_datapath.sv =====
module bedf_datapath
  import bedf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic [7:0]             ip_protocol,
  input  logic [7:0]             icmp_type,
  input  logic [7:0]             icmp_code,
  input  logic [ADDR_W-1:0]      dest_ip,
  input  logic [STAMP_W-1:0]     arrival_us,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic                   matched,
  output logic [COUNT_OUT_W-1:0] window_count,
  output logic                   attack
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > THRESH_W) ? CNT_W : THRESH_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(QUEUE_DEPTH);

  logic [THRESH_W-1:0] alarm_threshold;
  logic [WINDOW_W-1:0] window_us;
  logic [ADDR_W-1:0]   broadcast_addr;

  logic [7:0]          proto_q;
  logic [7:0]          type_q;
  logic [7:0]          code_q;
  logic [ADDR_W-1:0]   dest_q;
  logic [STAMP_W-1:0]  now_q;
  logic                hit;

  logic [STAMP_W-1:0]  mem [QUEUE_DEPTH];
  logic [STAMP_W-1:0]  rdata;
  logic [PTR_W-1:0]    read_ptr;
  logic [PTR_W-1:0]    read_ptr_next;
  logic [PTR_W-1:0]    write_ptr;
  logic [CNT_W-1:0]    entry_count;
  logic [CNT_W-1:0]    entry_count_next;
  logic [CNT_W-1:0]    push_count;
  logic                alarm_latched;
  logic                full;
  logic                do_pop;
  logic [STAMP_W-1:0]  age;

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_threshold <= RESET_THRESHOLD;
      window_us       <= RESET_WINDOW_US;
      broadcast_addr  <= RESET_BCAST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ALARM_THRESHOLD: alarm_threshold <= cfg_data[THRESH_W-1:0];
        REG_WINDOW_US:       window_us       <= cfg_data[WINDOW_W-1:0];
        REG_BROADCAST_ADDR:  broadcast_addr  <= cfg_data[ADDR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      proto_q <= ip_protocol;
      type_q  <= icmp_type;
      code_q  <= icmp_code;
      dest_q  <= dest_ip;
      now_q   <= arrival_us;
    end
  end

  assign full       = (entry_count >= FULL_CNT);
  assign do_pop     = cmd.pop || (cmd.push && full);
  assign push_count = full ? entry_count : entry_count + 1'b1;
  assign age        = now_q - rdata;

  always_comb begin
    read_ptr_next    = do_pop ? next_slot(read_ptr) : read_ptr;
    entry_count_next = entry_count;
    if (cmd.push) begin
      entry_count_next = push_count;
    end else if (cmd.pop) begin
      entry_count_next = entry_count - 1'b1;
    end
  end

  assign status.match    = !alarm_latched && proto_q == PROTO_ICMP &&
                           type_q == ICMP_ECHO_REQ && code_q == ICMP_CODE_PLAIN &&
                           dest_q == broadcast_addr;
  assign status.nonempty = (entry_count != '0);
  assign status.aged     = (age >= {{(STAMP_W-WINDOW_W){1'b0}}, window_us});

  // head entry is always fetched at the pointer it will hold next cycle
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[write_ptr] <= now_q;
    end
    rdata <= mem[read_ptr_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr      <= '0;
      write_ptr     <= '0;
      entry_count   <= '0;
      alarm_latched <= 1'b0;
    end else begin
      read_ptr    <= read_ptr_next;
      entry_count <= entry_count_next;
      if (cmd.push) begin
        write_ptr <= next_slot(write_ptr);
        if (CMP_W'(push_count) >= CMP_W'(alarm_threshold)) begin
          alarm_latched <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit <= 1'b0;
    end else if (cmd.push) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      matched      <= hit;
      window_count <= COUNT_OUT_W'(entry_count);
      attack       <= alarm_latched;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= FULL_CNT)
    else $error("entry count above queue depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> entry_count != '0)
    else $error("pop from empty queue");
  a_no_push_latched: assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !alarm_latched)
    else $error("transaction recorded after latch");
`endif

endmodule

// ===== rtl/core/broadcast_echo_flood_detector_unit.sv =====
// A transaction is captured on input accept in S_IDLE and classified in S_CHECK;
// a non-matching or post-alarm one goes straight to S_DONE, while a match passes
// through S_EVAL, which evicts aged entries, and S_PUSH. S_DONE loads the result
// once no held result waits on out_stall; no new transaction is taken before then.
// The eviction loop pops one queue entry per cycle through the read port.
// Reset (rst, synchronous): queue empty, flag cleared, registers at defaults.
module broadcast_echo_flood_detector_unit
  import bedf_pkg::*;
#(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             ip_protocol,
  input  logic [7:0]             icmp_type,
  input  logic [7:0]             icmp_code,
  input  logic [ADDR_W-1:0]      dest_ip,
  input  logic [STAMP_W-1:0]     arrival_us,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   matched,
  output logic [COUNT_OUT_W-1:0] window_count,
  output logic                   attack
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  bedf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bedf_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .ip_protocol  (ip_protocol),
    .icmp_type    (icmp_type),
    .icmp_code    (icmp_code),
    .dest_ip      (dest_ip),
    .arrival_us   (arrival_us),
    .cmd          (cmd),
    .status       (status),
    .matched      (matched),
    .window_count (window_count),
    .attack       (attack)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import bedf_pkg::*;

  localparam int QDEPTH     = 64;
  localparam int PHASES     = 8;
  localparam int PHASE_PKTS = 173;
  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_WAIT = 80;

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 2'd3;

  typedef struct packed {
    logic                   hit;
    logic [COUNT_OUT_W-1:0] cnt;
    logic                   atk;
  } verdict_t;

  typedef struct packed {
    logic                   is_reg;
    logic [CFG_INDEX_W-1:0] idx;
    logic [CFG_DATA_W-1:0]  data;
    logic [7:0]             pr;
    logic [7:0]             ty;
    logic [7:0]             co;
    logic [ADDR_W-1:0]      ds;
    logic [STAMP_W-1:0]     ts;
    logic                   typed;
    verdict_t               want;
  } step_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [7:0]             ip_protocol = '0;
  logic [7:0]             icmp_type = '0;
  logic [7:0]             icmp_code = '0;
  logic [ADDR_W-1:0]      dest_ip = '0;
  logic [STAMP_W-1:0]     arrival_us = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic                   matched;
  logic [COUNT_OUT_W-1:0] window_count;
  logic                   attack;

  // detector state as predicted
  logic [THRESH_W-1:0] thr_q = RESET_THRESHOLD;
  logic [WINDOW_W-1:0] win_q = RESET_WINDOW_US;
  logic [ADDR_W-1:0]   bcast_q = RESET_BCAST;
  logic                flag_q = 1'b0;
  logic [STAMP_W-1:0]  stamps[$];

  verdict_t verdicts_due[$];

  logic [STAMP_W-1:0] now_us = '0;
  int  burst_left = 0;
  bit  quiet = 1'b0;
  bit  stall_heavy = 1'b1;
  int  stall_left = 0;
  int  idle_cycles = 0;
  int  errors = 0;
  int  n_pkts = 0;
  int  n_hits = 0;
  int  n_full = 0;
  int  n_writes = 0;
  int  peak_count = 0;

  broadcast_echo_flood_detector_unit #(.QUEUE_DEPTH(QDEPTH)) DUT (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int survivors(input logic [STAMP_W-1:0] at);
    int k;
    logic [STAMP_W-1:0] age;
    logic [STAMP_W-1:0] lim;
    k = 0;
    lim = STAMP_W'(win_q);
    while (k < stamps.size()) begin
      age = at - stamps[k];
      if (age < lim) break;
      k++;
    end
    return stamps.size() - k;
  endfunction

  function automatic verdict_t flood_step(input logic [7:0] pr, ty, co,
                                          input logic [ADDR_W-1:0] ds,
                                          input logic [STAMP_W-1:0] ts);
    verdict_t v;
    int keep;
    v.hit = 1'b0;
    if (!flag_q && pr == PROTO_ICMP && ty == ICMP_ECHO_REQ && co == ICMP_CODE_PLAIN &&
        ds == bcast_q) begin
      keep = survivors(ts);
      while (stamps.size() > keep) void'(stamps.pop_front());
      if (stamps.size() >= QDEPTH) begin
        void'(stamps.pop_front());
        n_full++;
      end
      stamps.push_back(ts);
      v.hit = 1'b1;
      if (stamps.size() >= int'(thr_q)) flag_q = 1'b1;
    end
    v.cnt = COUNT_OUT_W'(stamps.size());
    v.atk = flag_q;
    return v;
  endfunction

  function automatic step_t pkt_row(input logic [7:0] pr, ty, co,
                                    input logic [ADDR_W-1:0] ds,
                                    input logic [STAMP_W-1:0] ts,
                                    input logic typed, input verdict_t want);
    step_t r;
    r = '0;
    r.pr = pr;
    r.ty = ty;
    r.co = co;
    r.ds = ds;
    r.ts = ts;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic step_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
    step_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  task automatic send_pkt(input logic [7:0] pr, ty, co, input logic [ADDR_W-1:0] ds,
                          input logic [STAMP_W-1:0] ts, input logic typed,
                          input verdict_t want);
    int gap;
    verdict_t v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = quiet ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    ip_protocol <= pr;
    icmp_type   <= ty;
    icmp_code   <= co;
    dest_ip     <= ds;
    arrival_us  <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    v = flood_step(pr, ty, co, ds, ts);
    n_pkts++;
    if (v.hit) n_hits++;
    if (int'(v.cnt) > peak_count) peak_count = int'(v.cnt);
    verdicts_due.push_back(typed ? want : v);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ALARM_THRESHOLD: thr_q = data[THRESH_W-1:0];
      REG_WINDOW_US:       win_q = data;
      REG_BROADCAST_ADDR:  bcast_q = data;
      default: ;
    endcase
    n_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_heavy && !out_stall && $urandom_range(0, 1) == 1) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end else begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin : check_result
    verdict_t v;
    if (!rst && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t unexpected transaction: expected none, got matched %0b count %0d attack %0b",
                 $time, matched, window_count, attack);
        errors++;
      end else begin
        v = verdicts_due.pop_front();
        if (matched !== v.hit) begin
          $display("%0t matched: expected %0b, got %0b", $time, v.hit, matched);
          errors++;
        end
        if (window_count !== v.cnt) begin
          $display("%0t window_count: expected %0d, got %0d", $time, v.cnt, window_count);
          errors++;
        end
        if (attack !== v.atk) begin
          $display("%0t attack: expected %0b, got %0b", $time, v.atk, attack);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t timeout: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    step_t plan[$];
    logic [7:0] pr;
    logic [7:0] ty;
    logic [7:0] co;
    logic [ADDR_W-1:0] ds;
    logic [THRESH_W-1:0] thr;
    logic [WINDOW_W-1:0] win;
    logic [ADDR_W-1:0] bc;
    logic [CFG_DATA_W-1:0] thr_word;
    logic [31:0] span;
    bit last;
    int n;

    plan.push_back(pkt_row(8'd0, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, RESET_BCAST, 48'd0,
                           1'b1, {1'b0, 7'd0, 1'b0}));
    plan.push_back(pkt_row(PROTO_ICMP, 8'd0, ICMP_CODE_PLAIN, RESET_BCAST, 48'd0,
                           1'b1, {1'b0, 7'd0, 1'b0}));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, 8'd255, RESET_BCAST, 48'd0,
                           1'b1, {1'b0, 7'd0, 1'b0}));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, 32'hFFFF_FFFE, 48'd0,
                           1'b1, {1'b0, 7'd0, 1'b0}));
    plan.push_back(pkt_row(8'd255, 8'd255, 8'd255, 32'd0, 48'd0,
                           1'b1, {1'b0, 7'd0, 1'b0}));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, RESET_BCAST, 48'd0,
                           1'b1, {1'b1, 7'd1, 1'b0}));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, RESET_BCAST, 48'd1,
                           1'b1, {1'b1, 7'd2, 1'b0}));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, RESET_BCAST,
                           48'd59_999_999, 1'b0, '0));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, RESET_BCAST,
                           48'd60_000_000, 1'b0, '0));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, RESET_BCAST,
                           48'hFFFF_FFFF_FFFF, 1'b0, '0));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, RESET_BCAST, 48'd0,
                           1'b0, '0));
    plan.push_back(reg_row(REG_BROADCAST_ADDR, 32'd0));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, 32'd0, 48'd5,
                           1'b0, '0));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, RESET_BCAST, 48'd6,
                           1'b0, '0));
    plan.push_back(reg_row(REG_WINDOW_US, 32'd0));
    // zero window: everything ages out, only the new stamp remains
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, 32'd0, 48'd10,
                           1'b1, {1'b1, 7'd1, 1'b0}));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, 32'd0, 48'd10,
                           1'b1, {1'b1, 7'd1, 1'b0}));
    plan.push_back(reg_row(REG_UNMAPPED, 32'h5A5A_A5A5));
    plan.push_back(reg_row(REG_WINDOW_US, 32'hFFFF_FFFF));
    plan.push_back(reg_row(REG_ALARM_THRESHOLD, 32'hFFFF_FFFF));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, ICMP_CODE_PLAIN, 32'd0,
                           48'hFFFF_0000_0000, 1'b0, '0));
    plan.push_back(pkt_row(PROTO_ICMP, ICMP_ECHO_REQ, 8'd1, 32'd0, 48'hFFFF_0000_0001,
                           1'b0, '0));

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        settle();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_pkt(plan[i].pr, plan[i].ty, plan[i].co, plan[i].ds, plan[i].ts,
                 plan[i].typed, plan[i].want);
      end
    end
    now_us = 48'hFFFF_0000_0001;

    for (int p = 0; p < PHASES; p++) begin
      last = (p == PHASES - 1);
      settle();
      case (p)
        0: begin thr = 7'd127; win = 32'hFFFF_FFFF; bc = RESET_BCAST; end
        1: begin thr = 7'd64; win = $urandom_range(1, 2000); bc = 32'd0; end
        2: begin thr = 7'($urandom_range(65, 126)); win = 32'd0; bc = $urandom; end
        3: begin thr = 7'd2; win = 32'd1; bc = $urandom; end
        4: begin thr = 7'($urandom_range(2, 64)); win = $urandom_range(100, 10000); bc = $urandom; end
        default: begin
          thr = 7'($urandom_range(2, 64));
          win = ($urandom_range(0, 1) == 1) ? $urandom : $urandom_range(1, 100000);
          bc = $urandom;
        end
      endcase
      // the last phase is allowed to raise the flag; it stays up until reset
      if (last) begin
        case ($urandom_range(0, 2))
          0: thr = 7'd0;
          1: thr = 7'd1;
          default: ;
        endcase
      end
      thr_word = $urandom;
      thr_word[THRESH_W-1:0] = thr;
      write_reg(REG_ALARM_THRESHOLD, thr_word);
      write_reg(REG_WINDOW_US, win);
      write_reg(REG_BROADCAST_ADDR, bc);
      quiet = (p % 2 == 0);
      stall_heavy = (p % 4 == 0) || (p % 4 == 3);

      if (p == 4) now_us = {STAMP_W{1'b1}} - STAMP_W'($urandom_range(0, 5000));
      else now_us = now_us + STAMP_W'(win_q) + STAMP_W'($urandom);
      span = (win_q == 0) ? 32'd50 : (win_q >> $urandom_range(3, 7)) + 32'd1;

      for (int k = 0; k < PHASE_PKTS; k++) begin
        if ($urandom_range(0, 39) == 0) begin
          now_us = now_us + STAMP_W'(win_q) + STAMP_W'($urandom_range(0, 1000));
        end else begin
          now_us = now_us + STAMP_W'($urandom_range(0, span));
        end
        pr = PROTO_ICMP;
        ty = ICMP_ECHO_REQ;
        co = ICMP_CODE_PLAIN;
        ds = bcast_q;
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 4))
            0: begin
              pr = 8'($urandom);
              ty = 8'($urandom);
              co = 8'($urandom);
              ds = $urandom;
            end
            1: pr = 8'($urandom);
            2: ty = 8'($urandom);
            3: co = 8'($urandom);
            default: ds = $urandom;
          endcase
        end
        // keep the flag down until the last phase: jump a full window ahead
        if (!last) begin
          n = survivors(now_us);
          if (n >= QDEPTH) n = QDEPTH - 1;
          if (n + 1 >= int'(thr_q)) now_us = now_us + STAMP_W'(win_q);
        end
        send_pkt(pr, ty, co, ds, now_us, 1'b0, '0);
      end
    end

    settle();
    repeat (DRAIN_WAIT) @(posedge clk);
    $display("Run: %0d packets, %0d recorded, peak window count %0d, %0d queue overflows",
             n_pkts, n_hits, peak_count, n_full);
    $display("Run: %0d register writes, attack flag %s at end",
             n_writes, flag_q ? "raised" : "clear");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
